/* sv/cbt_pkg.sv */
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and codes for the cumulative boundary table.
// ----------------------------------------------------------------------------
package cbt_pkg;

    typedef enum logic [2:0] {
        MODE_INSERT  = 3'd0,
        MODE_REPLACE = 3'd1,
        MODE_DELETE  = 3'd2,
        MODE_SWAP    = 3'd3,
        MODE_LOOKUP  = 3'd4,
        MODE_BOUNDS  = 3'd5
    } mode_t;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef enum logic [2:0] {
        POP_NONE  = 3'd0,
        POP_LD_S  = 3'd1,
        POP_LD_E  = 3'd2,
        POP_LD_S2 = 3'd3,
        POP_LD_E2 = 3'd4,
        POP_WRITE = 3'd5,
        POP_CMP   = 3'd6
    } pop_t;

    typedef enum logic [1:0] {
        DSEL_LEN  = 2'd0,
        DSEL_REPL = 2'd1,
        DSEL_DEL  = 2'd2,
        DSEL_SWAP = 2'd3
    } dsel_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_SETTLE = 8'b0000_0100,
        S_CALC1  = 8'b0000_1000,
        S_CALC2  = 8'b0001_0000,
        S_WALK   = 8'b0010_0000,
        S_DRAIN  = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic  load;
        logic  rd_en;
        logic  rd_zero;
        pop_t  pop;
        logic  calc1;
        logic  calc2;
        dsel_t dsel;
        logic  out_bounds;
        logic  out_lookup;
    } cmd_t;

endpackage

/* sv/cbt_ram.sv */
// ----------------------------------------------------------------------------
// cbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/cbt_ctrl.sv */
// ----------------------------------------------------------------------------
// cbt_ctrl
// Operation sequencer: checks each item, issues table reads and the walk.
// ----------------------------------------------------------------------------
module cbt_ctrl #(
    parameter int MAX_SEGMENTS = 256,
    parameter int AW           = $clog2(MAX_SEGMENTS),
    parameter int CNTW         = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        in_mode,
    input  logic [8:0]        in_index_a,
    input  logic [7:0]        in_index_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        status,
    output logic [8:0]        entry_count,
    output cbt_pkg::cmd_t     cmd,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr,
    output logic [CNTW-1:0]   tag,
    output logic [CNTW-1:0]   count
);

    localparam int IW  = (CNTW > 9) ? CNTW : 9;
    localparam int NXW = CNTW + 9;

    cbt_pkg::state_t state_reg, state_next;
    logic [2:0]      mode_reg, mode_next;
    logic [1:0]      status_reg, status_next;
    logic [CNTW-1:0] n_reg, n_next;
    logic [CNTW-1:0] lo_reg, lo_next;
    logic [CNTW-1:0] hi_reg, hi_next;
    logic [CNTW-1:0] k_reg, k_next;
    logic [CNTW-1:0] rem_reg, rem_next;
    logic [1:0]      step_reg, step_next;

    logic [IW-1:0]   n_ext, ia_ext, ib_ext, lo_ext, hi_ext;
    logic [1:0]      acc_status;
    logic [CNTW-1:0] km1, kp1, lom1, him1, cur_lo;
    logic [NXW-1:0]  n_wide;
    logic            accept;

    assign n_ext  = IW'(n_reg);
    assign ia_ext = IW'(in_index_a);
    assign ib_ext = IW'(in_index_b);
    assign lo_ext = (ia_ext < ib_ext) ? ia_ext : ib_ext;
    assign hi_ext = (ia_ext < ib_ext) ? ib_ext : ia_ext;
    assign accept = s_valid && s_ready;

    assign km1  = k_reg - 1'b1;
    assign kp1  = k_reg + 1'b1;
    assign lom1 = lo_reg - 1'b1;
    assign him1 = hi_reg - 1'b1;

    always_comb begin
        unique case (in_mode)
            cbt_pkg::MODE_INSERT: begin
                if (n_reg == CNTW'(MAX_SEGMENTS)) acc_status = cbt_pkg::STAT_FULL;
                else if (ia_ext > n_ext)          acc_status = cbt_pkg::STAT_IGNORED;
                else                              acc_status = cbt_pkg::STAT_DONE;
            end
            cbt_pkg::MODE_REPLACE, cbt_pkg::MODE_DELETE, cbt_pkg::MODE_BOUNDS: begin
                acc_status = (ia_ext >= n_ext) ? cbt_pkg::STAT_IGNORED : cbt_pkg::STAT_DONE;
            end
            cbt_pkg::MODE_SWAP: begin
                acc_status = (ia_ext >= n_ext || ib_ext >= n_ext) ?
                             cbt_pkg::STAT_IGNORED : cbt_pkg::STAT_DONE;
            end
            cbt_pkg::MODE_LOOKUP: acc_status = cbt_pkg::STAT_DONE;
            default:              acc_status = cbt_pkg::STAT_IGNORED;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        n_next      = n_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        k_next      = k_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        cmd         = '0;
        rd_addr     = '0;
        wr_addr     = '0;
        tag         = k_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cur_lo      = '0;

        unique case (state_reg)
            cbt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    cmd.load    = 1'b1;
                    mode_next   = in_mode;
                    status_next = acc_status;
                    step_next   = '0;
                    if (in_mode == cbt_pkg::MODE_SWAP) begin
                        cur_lo  = lo_ext[CNTW-1:0];
                        hi_next = hi_ext[CNTW-1:0];
                    end else begin
                        cur_lo  = ia_ext[CNTW-1:0];
                        hi_next = ia_ext[CNTW-1:0];
                    end
                    lo_next = cur_lo;
                    k_next  = cur_lo;
                    unique case (in_mode)
                        cbt_pkg::MODE_INSERT: begin
                            k_next   = n_reg;
                            rem_next = CNTW'(n_ext - ia_ext + 1'b1);
                        end
                        cbt_pkg::MODE_REPLACE: rem_next = CNTW'(n_ext - ia_ext);
                        cbt_pkg::MODE_DELETE:  rem_next = CNTW'(n_ext - ia_ext - 1'b1);
                        cbt_pkg::MODE_SWAP:    rem_next = CNTW'(hi_ext - lo_ext);
                        cbt_pkg::MODE_LOOKUP: begin
                            k_next   = '0;
                            rem_next = n_reg;
                        end
                        default: rem_next = '0;
                    endcase
                    if (acc_status != cbt_pkg::STAT_DONE) begin
                        state_next = cbt_pkg::S_RESP;
                    end else begin
                        unique case (in_mode)
                            cbt_pkg::MODE_INSERT: state_next = cbt_pkg::S_CALC1;
                            cbt_pkg::MODE_LOOKUP:
                                state_next = (n_reg == '0) ? cbt_pkg::S_DRAIN
                                                           : cbt_pkg::S_WALK;
                            cbt_pkg::MODE_SWAP:
                                state_next = (ia_ext == ib_ext) ? cbt_pkg::S_RESP
                                                                : cbt_pkg::S_LOAD;
                            default: state_next = cbt_pkg::S_LOAD;
                        endcase
                    end
                end
            end
            cbt_pkg::S_LOAD: begin
                cmd.rd_en = 1'b1;
                unique case (step_reg)
                    2'd0: begin
                        cmd.pop     = cbt_pkg::POP_LD_S;
                        cmd.rd_zero = (lo_reg == '0);
                        rd_addr     = lom1[AW-1:0];
                    end
                    2'd1: begin
                        cmd.pop = cbt_pkg::POP_LD_E;
                        rd_addr = lo_reg[AW-1:0];
                    end
                    2'd2: begin
                        cmd.pop     = cbt_pkg::POP_LD_S2;
                        cmd.rd_zero = (hi_reg == '0);
                        rd_addr     = him1[AW-1:0];
                    end
                    default: begin
                        cmd.pop = cbt_pkg::POP_LD_E2;
                        rd_addr = hi_reg[AW-1:0];
                    end
                endcase
                step_next = step_reg + 1'b1;
                if ((mode_reg == cbt_pkg::MODE_SWAP && step_reg == 2'd3) ||
                    (mode_reg != cbt_pkg::MODE_SWAP && step_reg == 2'd1)) begin
                    state_next = cbt_pkg::S_SETTLE;
                end
            end
            cbt_pkg::S_SETTLE: begin
                state_next = (mode_reg == cbt_pkg::MODE_BOUNDS) ? cbt_pkg::S_RESP
                                                                : cbt_pkg::S_CALC1;
            end
            cbt_pkg::S_CALC1: begin
                cmd.calc1  = 1'b1;
                state_next = cbt_pkg::S_CALC2;
            end
            cbt_pkg::S_CALC2: begin
                cmd.calc2 = 1'b1;
                unique case (mode_reg)
                    cbt_pkg::MODE_REPLACE: cmd.dsel = cbt_pkg::DSEL_REPL;
                    cbt_pkg::MODE_DELETE:  cmd.dsel = cbt_pkg::DSEL_DEL;
                    cbt_pkg::MODE_SWAP:    cmd.dsel = cbt_pkg::DSEL_SWAP;
                    default:               cmd.dsel = cbt_pkg::DSEL_LEN;
                endcase
                state_next = (rem_reg == '0) ? cbt_pkg::S_DRAIN : cbt_pkg::S_WALK;
            end
            cbt_pkg::S_WALK: begin
                cmd.rd_en = 1'b1;
                wr_addr   = k_reg[AW-1:0];
                unique case (mode_reg)
                    cbt_pkg::MODE_INSERT: begin
                        cmd.pop     = cbt_pkg::POP_WRITE;
                        cmd.rd_zero = (k_reg == '0);
                        rd_addr     = km1[AW-1:0];
                        k_next      = km1;
                    end
                    cbt_pkg::MODE_DELETE: begin
                        cmd.pop = cbt_pkg::POP_WRITE;
                        rd_addr = kp1[AW-1:0];
                        k_next  = kp1;
                    end
                    cbt_pkg::MODE_LOOKUP: begin
                        cmd.pop = cbt_pkg::POP_CMP;
                        rd_addr = k_reg[AW-1:0];
                        k_next  = kp1;
                    end
                    default: begin
                        cmd.pop = cbt_pkg::POP_WRITE;
                        rd_addr = k_reg[AW-1:0];
                        k_next  = kp1;
                    end
                endcase
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CNTW'(1)) begin
                    state_next = cbt_pkg::S_DRAIN;
                end
            end
            cbt_pkg::S_DRAIN: begin
                if (mode_reg == cbt_pkg::MODE_INSERT) begin
                    n_next = n_reg + 1'b1;
                end else if (mode_reg == cbt_pkg::MODE_DELETE) begin
                    n_next = n_reg - 1'b1;
                end
                state_next = cbt_pkg::S_RESP;
            end
            cbt_pkg::S_RESP: begin
                m_valid        = 1'b1;
                cmd.out_bounds = (mode_reg == cbt_pkg::MODE_BOUNDS) &&
                                 (status_reg == cbt_pkg::STAT_DONE);
                cmd.out_lookup = (mode_reg == cbt_pkg::MODE_LOOKUP);
                if (m_ready) begin
                    state_next = cbt_pkg::S_IDLE;
                end
            end
            default: state_next = cbt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbt_pkg::S_IDLE;
            n_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
        mode_reg   <= mode_next;
        status_reg <= status_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        k_reg      <= k_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
    end

    assign n_wide      = NXW'(n_reg);
    assign entry_count = n_wide[8:0];
    assign status      = status_reg;
    assign count       = n_reg;

endmodule

/* sv/cbt_dp.sv */
// ----------------------------------------------------------------------------
// cbt_dp
// Datapath: end-time table, segment lengths, offset adder and lookup compare.
// ----------------------------------------------------------------------------
module cbt_dp #(
    parameter int MAX_SEGMENTS = 256,
    parameter int TIME_WIDTH   = 40,
    parameter int AW           = $clog2(MAX_SEGMENTS),
    parameter int CNTW         = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbt_pkg::cmd_t     cmd,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CNTW-1:0]   tag,
    input  logic [CNTW-1:0]   count,
    input  logic [31:0]       in_seg_length,
    input  logic [39:0]       in_query_time,
    output logic [8:0]        found_index,
    output logic [39:0]       seg_start,
    output logic [39:0]       seg_end
);

    localparam int TW  = TIME_WIDTH;
    localparam int CW  = (TW > 40) ? TW : 40;
    localparam int FXW = CNTW + 9;

    logic [31:0]     len_reg;
    logic [39:0]     qt_reg;
    logic [TW-1:0]   s_reg, e_reg, s2_reg, e2_reg, l1_reg, l2_reg, delta_reg;
    logic            p_valid_reg;
    cbt_pkg::pop_t   p_pop_reg;
    logic            p_zero_reg;
    logic [AW-1:0]   p_waddr_reg;
    logic [CNTW-1:0] p_tag_reg;
    logic            found_reg;
    logic [CNTW-1:0] fidx_reg;

    logic [TW-1:0]   rdata, val, wdata;
    logic            we, hit;
    logic [CW-1:0]   s_ext, e_ext;
    logic [FXW-1:0]  f_ext;

    cbt_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (p_waddr_reg),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign val   = p_zero_reg ? '0 : rdata;
    assign wdata = val + delta_reg;
    assign we    = p_valid_reg && (p_pop_reg == cbt_pkg::POP_WRITE);
    assign hit   = p_valid_reg && (p_pop_reg == cbt_pkg::POP_CMP) &&
                   (CW'(qt_reg) < CW'(val));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= cmd.rd_en;
        end
        p_pop_reg   <= cmd.pop;
        p_zero_reg  <= cmd.rd_zero;
        p_waddr_reg <= wr_addr;
        p_tag_reg   <= tag;

        if (cmd.load) begin
            len_reg   <= in_seg_length;
            qt_reg    <= in_query_time;
            found_reg <= 1'b0;
            fidx_reg  <= count;
        end else if (hit && !found_reg) begin
            found_reg <= 1'b1;
            fidx_reg  <= p_tag_reg;
        end

        if (p_valid_reg) begin
            case (p_pop_reg)
                cbt_pkg::POP_LD_S:  s_reg  <= val;
                cbt_pkg::POP_LD_E:  e_reg  <= val;
                cbt_pkg::POP_LD_S2: s2_reg <= val;
                cbt_pkg::POP_LD_E2: e2_reg <= val;
                default: ;
            endcase
        end

        if (cmd.calc1) begin
            l1_reg <= e_reg - s_reg;
            l2_reg <= e2_reg - s2_reg;
        end

        if (cmd.calc2) begin
            case (cmd.dsel)
                cbt_pkg::DSEL_REPL: delta_reg <= TW'(len_reg) - l1_reg;
                cbt_pkg::DSEL_DEL:  delta_reg <= '0 - l1_reg;
                cbt_pkg::DSEL_SWAP: delta_reg <= l2_reg - l1_reg;
                default:            delta_reg <= TW'(len_reg);
            endcase
        end
    end

    assign s_ext       = CW'(s_reg);
    assign e_ext       = CW'(e_reg);
    assign f_ext       = FXW'(fidx_reg);
    assign seg_start   = cmd.out_bounds ? s_ext[39:0] : '0;
    assign seg_end     = cmd.out_bounds ? e_ext[39:0] : '0;
    assign found_index = cmd.out_lookup ? f_ext[8:0] : '0;

endmodule

/* sv/cumulative_boundary_table_unit.sv */
// ----------------------------------------------------------------------------
// cumulative_boundary_table_unit
// Ordered table of running segment end times with insert, replace, delete,
// swap, time lookup and bounds queries.
// ----------------------------------------------------------------------------
// Usage: one operation item on the s_ channel gives one result item on the
// m_ channel. The mode travels in s_tuser, the result status in m_tuser.
// The block works on one item at a time; s_tready is high only while idle.
// Bounds reads two entries and needs no walk; a refused item goes straight
// to the result.
// The walk over the stored entries moves one entry per cycle through the
// single read and single write port of the table memory. After m_tvalid
// the result holds until m_tready; the block returns to idle in the next
// cycle. Reset empties the table at once (the count clears, entries need
// no clearing).
// ----------------------------------------------------------------------------
module cumulative_boundary_table_unit #(
    parameter int MAX_SEGMENTS = 256,
    parameter int TIME_WIDTH   = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // index_a[8:0], index_b[16:9], seg_length[48:17],
                                    // query_time[88:49], zero pad
    input  logic [2:0]   s_tuser,   // mode[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // found_index[8:0], seg_start[48:9], seg_end[88:49],
                                    // entry_count[97:89], zero pad
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int AW   = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

    cbt_pkg::cmd_t   cmd;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [CNTW-1:0] tag, count;
    logic [8:0]      found_index, entry_count;
    logic [39:0]     seg_start, seg_end;
    logic [1:0]      status;

    cbt_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .in_mode     (s_tuser),
        .in_index_a  (s_tdata[8:0]),
        .in_index_b  (s_tdata[16:9]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .status      (status),
        .entry_count (entry_count),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .tag         (tag),
        .count       (count)
    );

    cbt_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .tag           (tag),
        .count         (count),
        .in_seg_length (s_tdata[48:17]),
        .in_query_time (s_tdata[88:49]),
        .found_index   (found_index),
        .seg_start     (seg_start),
        .seg_end       (seg_end)
    );

    assign m_tdata = {6'd0, entry_count, seg_end, seg_start, found_index};
    assign m_tuser = status;

endmodule

/* tb/sv/cumulative_boundary_table_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_boundary_table_unit_test
// Drives operation items into the boundary table and checks every result item
// against a cycle-free model of the table kept in the bench, with bursty
// input traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module cumulative_boundary_table_unit_test;

    localparam int          DEPTH      = 256;
    localparam int          IDLE_LIMIT = 20000;
    localparam logic [2:0]  MODE_SPARE6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  found;
        logic [39:0] sstart;
        logic [39:0] send;
        logic [8:0]  count;
    } table_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    logic [39:0]   end_tbl [DEPTH];
    int            seg_cnt;
    table_result_t pending_results [$];
    int            errors;
    int            idle_cycles;
    int            burst_left;
    int            items_sent;
    int            results_seen;
    int            full_refusals;
    int            stall_phase;
    int            stall_mode;

    cumulative_boundary_table_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [39:0] start_at(int k);
        return (k > 0) ? end_tbl[k-1] : 40'd0;
    endfunction

    function automatic void shift_ends(int from, int to_excl, logic [39:0] delta);
        for (int k = from; k < to_excl; k++) end_tbl[k] = end_tbl[k] + delta;
    endfunction

    function automatic table_result_t apply_op(logic [2:0] op, logic [8:0] ia, logic [7:0] ib,
                                               logic [31:0] len, logic [39:0] qt);
        table_result_t r;
        int n;
        int lo;
        int hi;
        logic [39:0] st;
        logic [39:0] old_len;
        logic [39:0] hi_len;
        r = '0;
        n = seg_cnt;
        case (op)
            cbt_pkg::MODE_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = cbt_pkg::STAT_FULL;
                end else if (ia > n) begin
                    r.status = cbt_pkg::STAT_IGNORED;
                end else begin
                    st = start_at(ia);
                    for (int k = n; k > ia; k--) end_tbl[k] = end_tbl[k-1];
                    end_tbl[ia] = st + 40'(len);
                    seg_cnt = n + 1;
                    shift_ends(ia + 1, n + 1, 40'(len));
                end
            end
            cbt_pkg::MODE_REPLACE: begin
                if (ia >= n) begin
                    r.status = cbt_pkg::STAT_IGNORED;
                end else begin
                    old_len = end_tbl[ia] - start_at(ia);
                    shift_ends(ia, n, 40'(len) - old_len);
                end
            end
            cbt_pkg::MODE_DELETE: begin
                if (ia >= n) begin
                    r.status = cbt_pkg::STAT_IGNORED;
                end else begin
                    old_len = end_tbl[ia] - start_at(ia);
                    for (int k = ia; k + 1 < n; k++) end_tbl[k] = end_tbl[k+1];
                    seg_cnt = n - 1;
                    shift_ends(ia, n - 1, 40'd0 - old_len);
                end
            end
            cbt_pkg::MODE_SWAP: begin
                if (ia >= n || ib >= n) begin
                    r.status = cbt_pkg::STAT_IGNORED;
                end else if (ia != ib) begin
                    lo = (ia < ib) ? ia : ib;
                    hi = (ia < ib) ? ib : ia;
                    old_len = end_tbl[lo] - start_at(lo);
                    hi_len = end_tbl[hi] - start_at(hi);
                    shift_ends(lo, hi, hi_len - old_len);
                end
            end
            cbt_pkg::MODE_LOOKUP: begin
                r.found = 9'(n);
                for (int k = 0; k < n; k++) begin
                    if (qt < end_tbl[k]) begin
                        r.found = 9'(k);
                        break;
                    end
                end
            end
            cbt_pkg::MODE_BOUNDS: begin
                if (ia >= n) begin
                    r.status = cbt_pkg::STAT_IGNORED;
                end else begin
                    r.sstart = start_at(ia);
                    r.send = end_tbl[ia];
                end
            end
            default: r.status = cbt_pkg::STAT_IGNORED;
        endcase
        r.count = 9'(seg_cnt);
        return r;
    endfunction

    task automatic send_item(logic [2:0] op, logic [8:0] ia, logic [7:0] ib,
                             logic [31:0] len, logic [39:0] qt);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, qt, len, ib, ia};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_op(op, ia, ib, len, qt));
        items_sent++;
        if (op == cbt_pkg::MODE_INSERT && seg_cnt == DEPTH &&
            pending_results[$].status == cbt_pkg::STAT_FULL)
            full_refusals++;
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((stall_phase / 4) % 3 != 0);
        endcase
    end

    always @(posedge aclk) begin
        table_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result item with nothing pending");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tuser != exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_tuser);
                    errors++;
                end
                if (m_tdata[8:0] != exp_r.found) begin
                    $error("found_index exp %0d got %0d", exp_r.found, m_tdata[8:0]);
                    errors++;
                end
                if (m_tdata[48:9] != exp_r.sstart) begin
                    $error("seg_start exp %h got %h", exp_r.sstart, m_tdata[48:9]);
                    errors++;
                end
                if (m_tdata[88:49] != exp_r.send) begin
                    $error("seg_end exp %h got %h", exp_r.send, m_tdata[88:49]);
                    errors++;
                end
                if (m_tdata[97:89] != exp_r.count) begin
                    $error("entry_count exp %0d got %0d", exp_r.count, m_tdata[97:89]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        send_item(cbt_pkg::MODE_LOOKUP, 9'd0, 8'd0, 32'd0, 40'hFF_FFFF_FFFF);
        send_item(cbt_pkg::MODE_BOUNDS, 9'd0, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_REPLACE, 9'd0, 8'd0, 32'd5, 40'd0);
        send_item(cbt_pkg::MODE_DELETE, 9'd0, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_SWAP, 9'd0, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd1, 8'd0, 32'd7, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd0, 8'd0, 32'hFFFF_FFFF, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd0, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd2, 8'd0, 32'd10, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd1, 8'd0, 32'd3, 40'd0);
        send_item(cbt_pkg::MODE_REPLACE, 9'd1, 8'd0, 32'hFFFF_FFFF, 40'd0);
        send_item(cbt_pkg::MODE_SWAP, 9'd2, 8'd2, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_SWAP, 9'd3, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_SWAP, 9'd1, 8'd4, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_BOUNDS, 9'd0, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_BOUNDS, 9'd3, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_BOUNDS, 9'd256, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_LOOKUP, 9'd0, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_LOOKUP, 9'd0, 8'd0, 32'd0, 40'hFF_FFFF_FFFF);
        send_item(MODE_SPARE6, 9'd1, 8'd1, 32'd1, 40'd1);
        send_item(MODE_SPARE7, 9'h1FF, 8'hFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        send_item(cbt_pkg::MODE_DELETE, 9'd3, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_DELETE, 9'd0, 8'd0, 32'd0, 40'd0);
        drain_all();
    endtask

    task automatic test_full_table();
        while (seg_cnt < DEPTH)
            send_item(cbt_pkg::MODE_INSERT, 9'($urandom_range(0, seg_cnt)), 8'd0,
                      32'hFFFF_FFFF - 32'($urandom_range(0, 3)), 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd0, 8'd0, 32'd1, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd256, 8'd0, 32'd1, 40'd0);
        send_item(cbt_pkg::MODE_BOUNDS, 9'd255, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_LOOKUP, 9'd0, 8'd0, 32'd0, 40'hFF_FFFF_FFFF);
        send_item(cbt_pkg::MODE_SWAP, 9'd0, 8'd255, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_DELETE, 9'd255, 8'd0, 32'd0, 40'd0);
        send_item(cbt_pkg::MODE_INSERT, 9'd255, 8'd0, 32'd9, 40'd0);
        drain_all();
        while (seg_cnt > 4)
            send_item(cbt_pkg::MODE_DELETE, 9'(seg_cnt - 1), 8'd0, 32'd0, 40'd0);
        drain_all();
    endtask

    task automatic random_op(int target);
        int r;
        int n;
        logic [2:0]  op;
        logic [8:0]  ia;
        logic [7:0]  ib;
        logic [31:0] len;
        logic [39:0] qt;
        n = seg_cnt;
        r = $urandom_range(0, 99);
        if (r < (n < target ? 40 : 15)) op = cbt_pkg::MODE_INSERT;
        else if (r < 50) op = cbt_pkg::MODE_REPLACE;
        else if (r < (n > target ? 70 : 58)) op = cbt_pkg::MODE_DELETE;
        else if (r < 75) op = cbt_pkg::MODE_SWAP;
        else if (r < 88) op = cbt_pkg::MODE_LOOKUP;
        else if (r < 98) op = cbt_pkg::MODE_BOUNDS;
        else op = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
        if ($urandom_range(0, 9) == 0) ia = 9'($urandom_range(0, 256));
        else if (op == cbt_pkg::MODE_INSERT) ia = 9'($urandom_range(0, n));
        else ia = (n > 0) ? 9'($urandom_range(0, n - 1)) : 9'd0;
        if ($urandom_range(0, 9) == 0 || n == 0) ib = 8'($urandom_range(0, 255));
        else ib = 8'($urandom_range(0, n - 1));
        len = $urandom_range(0, 2) == 0 ? $urandom() : 32'($urandom_range(0, 1000));
        if ($urandom_range(0, 1) == 0 || n == 0) begin
            qt = {8'($urandom()), 32'($urandom())};
        end else begin
            qt = end_tbl[$urandom_range(0, n - 1)] + 40'($urandom_range(0, 2)) - 40'd1;
        end
        send_item(op, ia, ib, len, qt);
    endtask

    task automatic test_random();
        repeat (500) random_op(20);
        drain_all();
        repeat (300) random_op(250);
        drain_all();
        repeat (560) random_op(8);
        drain_all();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        stall_phase = 0;
        stall_mode = 0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        items_sent = 0;
        results_seen = 0;
        full_refusals = 0;
        seg_cnt = 0;
        foreach (end_tbl[k]) end_tbl[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        test_random();
        repeat (300) @(posedge aclk);
        $display("covered %0d operation items and %0d result items, all six modes plus spare",
                 items_sent, results_seen);
        $display("full-table refusals %0d, final segment count %0d", full_refusals, seg_cnt);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
